@@ rtl/ssba_pkg.sv @@
package ssba_pkg;

	// Sizing of the slot map.
	localparam int NUM_SLOTS        = 1024;
	localparam int SECTORS_PER_SLOT = 8;

	// Field widths.
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 10;
	localparam int SECTOR_W = 13;
	localparam int LIMIT_W  = 11;

	// The map is held as rows of ROW_W used bits.
	localparam int ROW_W  = 32;
	localparam int ROWS   = NUM_SLOTS / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BIT_AW = $clog2(ROW_W);

	localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = LIMIT_W'(1024);
	localparam logic [LIMIT_W-1:0] NUM_SLOTS_LIM    = LIMIT_W'(NUM_SLOTS);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RECLAIM = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} ssba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_blocked;
	} ssba_stat_t;

	// Index of the lowest set bit of a row; zero when no bit is set.
	function automatic logic [BIT_AW-1:0] lowest_set(input logic [ROW_W-1:0] v);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_AW'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/ssba_if.sv @@
// Request channel: an operation and the slot it names.
interface ssba_req_if;
	logic                          valid;
	logic                          ready;
	logic [ssba_pkg::OP_W-1:0]     operation;
	logic [ssba_pkg::SLOT_W-1:0]   slot_index;

	modport source (output valid, output operation, output slot_index, input ready);
	modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

// Response channel: one result per request.
interface ssba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ssba_pkg::SLOT_W-1:0]   granted_slot;
	logic                          status;
	logic [ssba_pkg::SECTOR_W-1:0] first_sector;

	modport source (output valid, output granted_slot, output status, output first_sector,
		input ready);
	modport sink   (input valid, input granted_slot, input status, input first_sector,
		output ready);
endinterface

@@ rtl/swap_slot_bitmap_allocator.sv @@
// The map row is read into rd_q at the request transfer; the result enters the output
// register at the commit in ST_EVAL, which waits while that register is held. A new request
// is taken only in idle, after the commit, as the map row read and row write require.
// A finished result waits in the output register while the next request is taken.
// Reset clears the used map at once through per-row valid flags, with no clearing pass,
// and sets the slot limit to 1024.
module swap_slot_bitmap_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	ssba_req_if.sink                     req,
	ssba_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [ssba_pkg::LIMIT_W-1:0] cfg_wdata
);
	import ssba_pkg::*;

	ssba_cmd_t  cmd;
	ssba_stat_t stat;

	// Sequencing of each request.
	ssba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Map storage, search and result register.
	ssba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.operation    (req.operation),
		.slot_index   (req.slot_index),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.granted_slot (rsp.granted_slot),
		.status       (rsp.status),
		.first_sector (rsp.first_sector)
	);

endmodule

@@ rtl/ssba_ctrl.sv @@
module ssba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ssba_pkg::ssba_stat_t stat,
	output ssba_pkg::ssba_cmd_t  cmd
);
	import ssba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// A request is taken only in idle; the result register is separate.
	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_EVAL) && !stat.out_blocked;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!stat.out_blocked) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/ssba_dp.sv @@
module ssba_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssba_pkg::ssba_cmd_t            cmd,
	output ssba_pkg::ssba_stat_t           stat,
	input  logic                           cfg_we,
	input  logic [ssba_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic [ssba_pkg::OP_W-1:0]      operation,
	input  logic [ssba_pkg::SLOT_W-1:0]    slot_index,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [ssba_pkg::SLOT_W-1:0]    granted_slot,
	output logic                           status,
	output logic [ssba_pkg::SECTOR_W-1:0]  first_sector
);
	import ssba_pkg::*;

	// Map storage, one row per address, with per-row valid and full flags.
	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROW_W-1:0]  rd_q;
	logic [ROWS-1:0]   row_valid_q;
	logic [ROWS-1:0]   row_full_q;

	logic [LIMIT_W-1:0] slot_limit_q;
	logic [LIMIT_W-1:0] lim;

	// Request captured at the transfer.
	logic [OP_W-1:0]   op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_AW-1:0] row_q;
	logic              row_found_q;

	// Output register.
	logic                rsp_valid_q;
	logic [SLOT_W-1:0]   granted_q;
	logic                status_q;
	logic [SECTOR_W-1:0] sector_q;

	logic [ROW_AW-1:0] first_row;
	logic              any_row;
	logic [ROW_AW-1:0] rd_addr;

	logic [ROW_W-1:0]  word;
	logic [ROW_W-1:0]  usable;
	logic [ROW_W-1:0]  free_bits;
	logic [BIT_AW-1:0] bit_sel;
	logic [ROW_W-1:0]  wr_word;
	logic [SLOT_W-1:0] res_slot;
	logic              res_ok;
	logic [SECTOR_W-1:0] res_sector;

	assign lim = (slot_limit_q > NUM_SLOTS_LIM) ? NUM_SLOTS_LIM : slot_limit_q;

	// Lowest row that still has a clear bit.
	always_comb begin
		first_row = '0;
		any_row   = 1'b0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (!row_full_q[i]) begin
				first_row = ROW_AW'(i);
				any_row   = 1'b1;
			end
		end
	end

	assign rd_addr = (operation == OP_ALLOC) ? first_row : slot_index[BIT_AW +: ROW_AW];

	// Row read at the transfer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Row write when the result is committed.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem[row_q] <= wr_word;
		end
	end

	// Valid and full flags; reset marks every row empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_full_q  <= '0;
		end else if (cmd.commit) begin
			row_valid_q[row_q] <= 1'b1;
			row_full_q[row_q]  <= &wr_word;
		end
	end

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= SLOT_LIMIT_RESET;
		end else if (cfg_we) begin
			slot_limit_q <= cfg_wdata;
		end
	end

	// Capture the request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= operation;
			slot_q      <= slot_index;
			row_q       <= rd_addr;
			row_found_q <= any_row;
		end
	end

	// Evaluate the operation against the row that was read.
	always_comb begin
		word = row_valid_q[row_q] ? rd_q : '0;
		for (int b = 0; b < ROW_W; b++) begin
			usable[b] = LIMIT_W'({row_q, BIT_AW'(b)}) < lim;
		end
		free_bits = ~word & usable;
		bit_sel   = (op_q == OP_ALLOC) ? lowest_set(free_bits) : slot_q[BIT_AW-1:0];
		wr_word   = word;
		res_slot  = slot_q;
		res_ok    = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				res_slot = '0;
				if (row_found_q && (|free_bits)) begin
					wr_word[bit_sel] = 1'b1;
					res_slot         = SLOT_W'({row_q, bit_sel});
					res_ok           = 1'b1;
				end
			end
			OP_RECLAIM: begin
				if (usable[bit_sel] && word[bit_sel]) begin
					wr_word[bit_sel] = 1'b0;
					res_ok           = 1'b1;
				end
			end
			OP_FREE: begin
				if (usable[bit_sel]) begin
					wr_word[bit_sel] = 1'b0;
				end
				res_ok = 1'b1;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
		res_sector = res_ok ? SECTOR_W'(res_slot * SECTORS_PER_SLOT) : '0;
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q <= res_slot;
			status_q  <= !res_ok;
			sector_q  <= res_sector;
		end
	end

	assign stat.out_blocked = rsp_valid_q && !rsp_ready;
	assign rsp_valid        = rsp_valid_q;
	assign granted_slot     = granted_q;
	assign status           = status_q;
	assign first_sector     = sector_q;

`ifndef NO_ASSERTIONS
	// A result is never committed over one that has not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(rsp_valid_q && !rsp_ready))
		else $error("result committed while output register is held");

	// The full flag of a written row tracks the data written to it.
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> row_full_q[$past(row_q)] == (&$past(wr_word)))
		else $error("row full flag out of step with row data");

	// An allocated slot always lies below the active limit.
	a_alloc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_ALLOC && res_ok) |-> (LIMIT_W'(res_slot) < lim))
		else $error("slot allocated at or above the limit");
`endif

endmodule
